FILE: sv/sfa_pkg.sv
`default_nettype none
package sfa_pkg;

	// heap geometry and block sizes
	localparam int HEAP_BYTES_DEF = 65536;
	localparam int CLASS_COUNT    = 12;
	localparam int MIN_BLOCK      = 24;
	localparam int INIT_BREAK     = 280;
	localparam int INIT_HEAD_CLS  = 5;
	localparam int INIT_HEAD_BP   = 112;
	localparam int CHUNK_RESET    = 168;
	localparam int LIMIT_RESET    = 65536;

	// request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// result codes
	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_NULL = 2'd1;
	localparam logic [1:0] STAT_OOM  = 2'd2;

	// configuration register indexes
	localparam logic CFG_EXTEND_CHUNK = 1'b0;
	localparam logic CFG_HEAP_LIMIT   = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] request_size;
		logic [15:0] block_addr;
	} item_t;

	typedef struct packed {
		logic [15:0] result_addr;
		logic [1:0]  status;
	} result_t;

	typedef enum logic [5:0] {
		S_INIT, S_IDLE, S_FIN,
		S_F0, S_F1, S_F2, S_F3, S_F4, S_F5,
		S_M0, S_M1, S_M2,
		S_MP1, S_MP2, S_MP3, S_MP4,
		S_MN0, S_MN1, S_MN2, S_MN3, S_MN4, S_MN5, S_MN6, S_MN7, S_MN8,
		S_FC, S_FW, S_FR, S_FN,
		S_GCHK, S_G0, S_G1, S_G2, S_G3, S_G4,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_LA0, S_LA1, S_LA2,
		S_LD0, S_LD1, S_LD2, S_LD3
	} state_t;

	// size class of a block size
	function automatic logic [3:0] class_of(input logic [31:0] size);
		logic [3:0] c;
		if (size <= 32'd24) c = 4'd0;
		else if (size <= 32'd48) c = 4'd1;
		else if (size <= 32'd72) c = 4'd2;
		else if (size <= 32'd96) c = 4'd3;
		else if (size <= 32'd120) c = 4'd4;
		else if (size <= 32'd480) c = 4'd5;
		else if (size <= 32'd960) c = 4'd6;
		else if (size <= 32'd1920) c = 4'd7;
		else if (size <= 32'd3840) c = 4'd8;
		else if (size <= 32'd7680) c = 4'd9;
		else if (size <= 32'd15360) c = 4'd10;
		else c = 4'd11;
		return c;
	endfunction

	// initial heap image: prologue, first free block, epilogue
	function automatic logic [31:0] init_addr(input logic [2:0] i);
		logic [31:0] a;
		case (i)
			3'd0: a = 32'd96;
			3'd1: a = 32'd100;
			3'd2: a = 32'd104;
			3'd3: a = 32'd108;
			3'd4: a = 32'd112;
			3'd5: a = 32'd120;
			3'd6: a = 32'd272;
			default: a = 32'd276;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] init_data(input logic [2:0] i);
		logic [31:0] d;
		case (i)
			3'd1, 3'd2: d = 32'd9;
			3'd3, 3'd6: d = 32'd170;
			3'd7: d = 32'd1;
			default: d = 32'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sfa_mem.sv
`default_nettype none
module sfa_mem #(
	parameter int WORDS = sfa_pkg::HEAP_BYTES_DEF / 4,
	localparam int IW = $clog2(WORDS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [IW-1:0] idx,
	input  wire logic [31:0]   wdata,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [WORDS];

	// single port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx] <= wdata;
		end else begin
			rdata <= mem[idx];
		end
	end

endmodule
`default_nettype wire

FILE: sv/sfa_ctrl.sv
`default_nettype none
module sfa_ctrl #(
	parameter int HEAP_BYTES = sfa_pkg::HEAP_BYTES_DEF,
	localparam int IW = $clog2(HEAP_BYTES / 4)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sfa_pkg::item_t  item,
	input  wire logic            in_fire,
	output logic                 in_ready,
	output sfa_pkg::result_t     res,
	output logic                 res_valid,
	input  wire logic            res_take,
	input  wire logic [12:0]     extend_chunk_bytes,
	input  wire logic [16:0]     heap_limit_bytes,
	output logic                 mem_we,
	output logic      [IW-1:0]   mem_idx,
	output logic      [31:0]     mem_wdata,
	input  wire logic [31:0]     mem_rdata
);

	localparam int WALK_LIMIT = HEAP_BYTES / 24 + 1;
	localparam int WW = $clog2(WALK_LIMIT + 1);
	localparam logic [31:0] HEAP_LIM = 32'(HEAP_BYTES);
	localparam logic [3:0] CLS_END = 4'(sfa_pkg::CLASS_COUNT);

	sfa_pkg::state_t state_q, state_d, ret_q, mret;

	logic [31:0] bp_q, sz_q, nx_q, nsz_q, psz_q, pv_q, h_q, v_q, cur_q, rem_q;
	logic [31:0] sub_bp_q, sub_sz_q, ldnx_q, ldpv_q;
	logic [16:0] asize_q, ext_q, break_q;
	logic [15:0] head_q;
	logic [15:0] heads_q [sfa_pkg::CLASS_COUNT];
	logic [3:0]  cls_q, cls_sub;
	logic [WW-1:0] walk_q;
	logic [2:0]  init_q;
	logic        pa_q, na_q, is_free_q;
	logic [15:0] res_addr_q;
	logic [1:0]  res_status_q;

	logic [31:0] w_size, mem_a, lim_c;
	logic [16:0] chunk8, ext_c, asize_c;
	logic [17:0] sum_c;
	logic        oom, fit, walk_end;

	// shared datapath terms
	always_comb begin
		w_size  = {mem_rdata[31:3], 3'b000};
		cls_sub = sfa_pkg::class_of(sub_sz_q);
		mret    = is_free_q ? sfa_pkg::S_FIN : sfa_pkg::S_P0;
		chunk8  = {4'b0, extend_chunk_bytes[12:3], 3'b000};
		ext_c   = (asize_q > chunk8) ? asize_q : chunk8;
		lim_c   = ({15'b0, heap_limit_bytes} > HEAP_LIM) ? HEAP_LIM : {15'b0, heap_limit_bytes};
		sum_c   = {1'b0, break_q} + {1'b0, ext_c};
		oom     = {14'b0, sum_c} > lim_c;
		fit     = {15'b0, asize_q} <= w_size;
		walk_end = (bp_q == 32'd0) || (walk_q == WW'(WALK_LIMIT));
		asize_c = (item.request_size <= 16'd16) ? 17'(sfa_pkg::MIN_BLOCK)
			: ((17'(item.request_size) + 17'd11) & ~17'd7);
		in_ready  = (state_q == sfa_pkg::S_IDLE);
		res_valid = (state_q == sfa_pkg::S_FIN);
		res.result_addr = res_addr_q;
		res.status      = res_status_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfa_pkg::S_INIT: if (init_q == 3'd7) state_d = sfa_pkg::S_IDLE;
			sfa_pkg::S_IDLE: begin
				if (in_fire) begin
					if (item.action == sfa_pkg::ACT_FREE) begin
						state_d = (item.block_addr == 16'd0) ? sfa_pkg::S_FIN : sfa_pkg::S_F0;
					end else begin
						state_d = (item.request_size == 16'd0) ? sfa_pkg::S_FIN : sfa_pkg::S_FC;
					end
				end
			end
			sfa_pkg::S_FIN: if (res_take) state_d = sfa_pkg::S_IDLE;
			sfa_pkg::S_F0:  state_d = sfa_pkg::S_F1;
			sfa_pkg::S_F1:  state_d = sfa_pkg::S_F2;
			sfa_pkg::S_F2:  state_d = sfa_pkg::S_F3;
			sfa_pkg::S_F3:  state_d = sfa_pkg::S_F4;
			sfa_pkg::S_F4:  state_d = sfa_pkg::S_F5;
			sfa_pkg::S_F5:  state_d = sfa_pkg::S_LA0;
			sfa_pkg::S_M0:  state_d = sfa_pkg::S_M1;
			sfa_pkg::S_M1:  state_d = sfa_pkg::S_M2;
			sfa_pkg::S_M2: begin
				if (pa_q && mem_rdata[0]) state_d = mret;
				else if (pa_q) state_d = sfa_pkg::S_LD0;
				else state_d = sfa_pkg::S_MN0;
			end
			sfa_pkg::S_MP1: state_d = sfa_pkg::S_LD0;
			sfa_pkg::S_MP2: state_d = sfa_pkg::S_MP3;
			sfa_pkg::S_MP3: state_d = sfa_pkg::S_MP4;
			sfa_pkg::S_MP4: state_d = sfa_pkg::S_LA0;
			sfa_pkg::S_MN0: state_d = sfa_pkg::S_MN1;
			sfa_pkg::S_MN1: state_d = sfa_pkg::S_MN2;
			sfa_pkg::S_MN2: state_d = sfa_pkg::S_LD0;
			sfa_pkg::S_MN3: state_d = sfa_pkg::S_LD0;
			sfa_pkg::S_MN4: state_d = na_q ? sfa_pkg::S_MN5 : sfa_pkg::S_LD0;
			sfa_pkg::S_MN5: state_d = sfa_pkg::S_MN6;
			sfa_pkg::S_MN6: state_d = sfa_pkg::S_MN7;
			sfa_pkg::S_MN7: state_d = sfa_pkg::S_MN8;
			sfa_pkg::S_MN8: state_d = sfa_pkg::S_LA0;
			sfa_pkg::S_FC:  state_d = (cls_q == CLS_END) ? sfa_pkg::S_GCHK : sfa_pkg::S_FW;
			sfa_pkg::S_FW:  state_d = walk_end ? sfa_pkg::S_FC : sfa_pkg::S_FR;
			sfa_pkg::S_FR:  state_d = fit ? sfa_pkg::S_P0 : sfa_pkg::S_FN;
			sfa_pkg::S_FN:  state_d = sfa_pkg::S_FW;
			sfa_pkg::S_GCHK: state_d = oom ? sfa_pkg::S_FIN : sfa_pkg::S_G0;
			sfa_pkg::S_G0:  state_d = sfa_pkg::S_G1;
			sfa_pkg::S_G1:  state_d = sfa_pkg::S_G2;
			sfa_pkg::S_G2:  state_d = sfa_pkg::S_G3;
			sfa_pkg::S_G3:  state_d = sfa_pkg::S_LA0;
			sfa_pkg::S_G4:  state_d = sfa_pkg::S_M0;
			sfa_pkg::S_P0:  state_d = sfa_pkg::S_P1;
			sfa_pkg::S_P1:  state_d = sfa_pkg::S_LD0;
			sfa_pkg::S_P2:  state_d = sfa_pkg::S_P3;
			sfa_pkg::S_P3:  state_d = (rem_q >= 32'(sfa_pkg::MIN_BLOCK)) ? sfa_pkg::S_P4
				: sfa_pkg::S_P7;
			sfa_pkg::S_P4:  state_d = sfa_pkg::S_P5;
			sfa_pkg::S_P5:  state_d = sfa_pkg::S_P6;
			sfa_pkg::S_P6:  state_d = sfa_pkg::S_LA0;
			sfa_pkg::S_P7:  state_d = sfa_pkg::S_P8;
			sfa_pkg::S_P8:  state_d = sfa_pkg::S_P9;
			sfa_pkg::S_P9:  state_d = sfa_pkg::S_FIN;
			sfa_pkg::S_LA0: state_d = sfa_pkg::S_LA1;
			sfa_pkg::S_LA1: state_d = sfa_pkg::S_LA2;
			sfa_pkg::S_LA2: state_d = ret_q;
			sfa_pkg::S_LD0: state_d = sfa_pkg::S_LD1;
			sfa_pkg::S_LD1: state_d = sfa_pkg::S_LD2;
			sfa_pkg::S_LD2: state_d = sfa_pkg::S_LD3;
			sfa_pkg::S_LD3: state_d = ret_q;
			default: state_d = sfa_pkg::S_IDLE;
		endcase
	end

	// heap memory access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_a     = bp_q - 32'd4;
		mem_wdata = 32'd0;
		case (state_q)
			sfa_pkg::S_INIT: begin
				mem_we    = 1'b1;
				mem_a     = sfa_pkg::init_addr(init_q);
				mem_wdata = sfa_pkg::init_data(init_q);
			end
			sfa_pkg::S_F1: begin
				mem_we    = 1'b1;
				mem_wdata = w_size | {30'b0, mem_rdata[1], 1'b0};
			end
			sfa_pkg::S_F2: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + sz_q - 32'd8;
				mem_wdata = h_q;
			end
			sfa_pkg::S_F3: mem_a = bp_q + sz_q - 32'd4;
			sfa_pkg::S_F4: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + sz_q - 32'd4;
				mem_wdata = {mem_rdata[31:3], 2'b00, mem_rdata[0]};
			end
			sfa_pkg::S_M1: mem_a = bp_q + w_size - 32'd4;
			sfa_pkg::S_MP2: begin
				mem_we    = 1'b1;
				mem_wdata = (sz_q + nsz_q) | {30'b0, pa_q, 1'b0};
			end
			sfa_pkg::S_MP3: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + sz_q - 32'd8;
				mem_wdata = sz_q | {30'b0, pa_q, 1'b0};
			end
			sfa_pkg::S_MN0: mem_a = bp_q - 32'd8;
			sfa_pkg::S_MN1: mem_a = bp_q - w_size - 32'd4;
			sfa_pkg::S_MN5: mem_a = pv_q - 32'd4;
			sfa_pkg::S_MN6: begin
				mem_we    = 1'b1;
				mem_a     = pv_q - 32'd4;
				mem_wdata = sz_q | {30'b0, mem_rdata[1], 1'b0};
			end
			sfa_pkg::S_MN7: begin
				mem_we    = 1'b1;
				mem_a     = pv_q + sz_q - 32'd8;
				mem_wdata = h_q;
			end
			sfa_pkg::S_FR: mem_a = bp_q;
			sfa_pkg::S_G1: begin
				mem_we    = 1'b1;
				mem_wdata = {15'b0, ext_q} | {30'b0, mem_rdata[1], 1'b0};
			end
			sfa_pkg::S_G2: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + {15'b0, ext_q} - 32'd8;
				mem_wdata = h_q;
			end
			sfa_pkg::S_G4: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + {15'b0, ext_q} - 32'd4;
				mem_wdata = 32'd1;
			end
			sfa_pkg::S_P3: begin
				mem_we    = 1'b1;
				mem_wdata = ((rem_q >= 32'(sfa_pkg::MIN_BLOCK)) ? {15'b0, asize_q} : cur_q)
					| {30'b0, mem_rdata[1], 1'b1};
			end
			sfa_pkg::S_P4: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + {15'b0, asize_q} - 32'd4;
				mem_wdata = rem_q | 32'd2;
			end
			sfa_pkg::S_P5: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + {15'b0, asize_q} + rem_q - 32'd8;
				mem_wdata = rem_q | 32'd2;
			end
			sfa_pkg::S_P7: mem_a = bp_q + cur_q - 32'd4;
			sfa_pkg::S_P8: begin
				mem_we    = 1'b1;
				mem_a     = bp_q + cur_q - 32'd4;
				mem_wdata = mem_rdata | 32'd2;
			end
			sfa_pkg::S_P9: begin
				mem_we    = ~v_q[0];
				mem_a     = bp_q + cur_q + {v_q[31:3], 3'b000} - 32'd8;
				mem_wdata = v_q;
			end
			sfa_pkg::S_LA0: begin
				mem_we    = 1'b1;
				mem_a     = sub_bp_q;
				mem_wdata = {16'b0, heads_q[cls_sub]};
			end
			sfa_pkg::S_LA1: begin
				mem_we    = 1'b1;
				mem_a     = sub_bp_q + 32'd8;
			end
			sfa_pkg::S_LA2: begin
				mem_we    = (head_q != 16'd0);
				mem_a     = {16'b0, head_q} + 32'd8;
				mem_wdata = sub_bp_q;
			end
			sfa_pkg::S_LD0: mem_a = sub_bp_q;
			sfa_pkg::S_LD1: mem_a = sub_bp_q + 32'd8;
			sfa_pkg::S_LD2: begin
				mem_we    = (mem_rdata != 32'd0);
				mem_a     = mem_rdata;
				mem_wdata = ldnx_q;
			end
			sfa_pkg::S_LD3: begin
				mem_we    = (ldnx_q != 32'd0);
				mem_a     = ldnx_q + 32'd8;
				mem_wdata = ldpv_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
		mem_idx = mem_a[IW+1:2];
	end

	// control state, list heads and break
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfa_pkg::S_INIT;
			init_q  <= 3'd0;
			break_q <= 17'(sfa_pkg::INIT_BREAK);
			for (int i = 0; i < sfa_pkg::CLASS_COUNT; i++) begin
				heads_q[i] <= (i == sfa_pkg::INIT_HEAD_CLS) ? 16'(sfa_pkg::INIT_HEAD_BP) : 16'd0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == sfa_pkg::S_INIT) init_q <= init_q + 3'd1;
			if (state_q == sfa_pkg::S_G4) break_q <= bp_q[16:0] + ext_q;
			if (state_q == sfa_pkg::S_LA0) heads_q[cls_sub] <= sub_bp_q[15:0];
			if (state_q == sfa_pkg::S_LD2 && mem_rdata == 32'd0) begin
				heads_q[cls_sub] <= ldnx_q[15:0];
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			sfa_pkg::S_IDLE: begin
				res_addr_q   <= 16'd0;
				res_status_q <= sfa_pkg::STAT_DONE;
				bp_q         <= {16'b0, item.block_addr};
				is_free_q    <= 1'b1;
				asize_q      <= asize_c;
				cls_q        <= sfa_pkg::class_of({15'b0, asize_c});
				if (item.action == sfa_pkg::ACT_FREE) begin
					if (item.block_addr == 16'd0) res_status_q <= sfa_pkg::STAT_NULL;
				end else if (item.request_size == 16'd0) begin
					res_status_q <= sfa_pkg::STAT_NULL;
				end
			end
			sfa_pkg::S_F1: begin
				sz_q <= w_size;
				h_q  <= w_size | {30'b0, mem_rdata[1], 1'b0};
			end
			sfa_pkg::S_F5: begin
				sub_bp_q <= bp_q;
				sub_sz_q <= sz_q;
				ret_q    <= sfa_pkg::S_M0;
			end
			sfa_pkg::S_M1: begin
				sz_q <= w_size;
				pa_q <= mem_rdata[1];
				nx_q <= bp_q + w_size;
			end
			sfa_pkg::S_M2: begin
				na_q     <= mem_rdata[0];
				nsz_q    <= mem_rdata[0] ? 32'd0 : w_size;
				sub_bp_q <= bp_q;
				sub_sz_q <= sz_q;
				ret_q    <= sfa_pkg::S_MP1;
			end
			sfa_pkg::S_MP1: begin
				sub_bp_q <= nx_q;
				sub_sz_q <= nsz_q;
				ret_q    <= sfa_pkg::S_MP2;
			end
			sfa_pkg::S_MP2: sz_q <= sz_q + nsz_q;
			sfa_pkg::S_MP4: begin
				sub_bp_q <= bp_q;
				sub_sz_q <= sz_q;
				ret_q    <= mret;
			end
			sfa_pkg::S_MN1: pv_q <= bp_q - w_size;
			sfa_pkg::S_MN2: begin
				psz_q    <= w_size;
				sub_bp_q <= bp_q;
				sub_sz_q <= sz_q;
				ret_q    <= sfa_pkg::S_MN3;
			end
			sfa_pkg::S_MN3: begin
				sub_bp_q <= pv_q;
				sub_sz_q <= psz_q;
				ret_q    <= sfa_pkg::S_MN4;
			end
			sfa_pkg::S_MN4: begin
				sub_bp_q <= nx_q;
				sub_sz_q <= nsz_q;
				ret_q    <= sfa_pkg::S_MN5;
			end
			sfa_pkg::S_MN5: sz_q <= sz_q + psz_q + nsz_q;
			sfa_pkg::S_MN6: h_q <= sz_q | {30'b0, mem_rdata[1], 1'b0};
			sfa_pkg::S_MN8: begin
				bp_q     <= pv_q;
				sub_bp_q <= pv_q;
				sub_sz_q <= sz_q;
				ret_q    <= mret;
			end
			sfa_pkg::S_FC: begin
				if (cls_q != CLS_END) bp_q <= {16'b0, heads_q[cls_q]};
				walk_q <= '0;
			end
			sfa_pkg::S_FW: if (walk_end) cls_q <= cls_q + 4'd1;
			sfa_pkg::S_FN: begin
				bp_q   <= mem_rdata;
				walk_q <= walk_q + 1'b1;
			end
			sfa_pkg::S_GCHK: begin
				ext_q     <= ext_c;
				bp_q      <= {15'b0, break_q};
				is_free_q <= 1'b0;
				if (oom) res_status_q <= sfa_pkg::STAT_OOM;
			end
			sfa_pkg::S_G1: h_q <= {15'b0, ext_q} | {30'b0, mem_rdata[1], 1'b0};
			sfa_pkg::S_G3: begin
				sub_bp_q <= bp_q;
				sub_sz_q <= {15'b0, ext_q};
				ret_q    <= sfa_pkg::S_G4;
			end
			sfa_pkg::S_P1: begin
				cur_q    <= w_size;
				rem_q    <= w_size - {15'b0, asize_q};
				sub_bp_q <= bp_q;
				sub_sz_q <= w_size;
				ret_q    <= sfa_pkg::S_P2;
			end
			sfa_pkg::S_P3: res_addr_q <= bp_q[15:0];
			sfa_pkg::S_P6: begin
				sub_bp_q <= bp_q + {15'b0, asize_q};
				sub_sz_q <= rem_q;
				ret_q    <= sfa_pkg::S_FIN;
			end
			sfa_pkg::S_P8: v_q <= mem_rdata | 32'd2;
			sfa_pkg::S_LA0: head_q <= heads_q[cls_sub];
			sfa_pkg::S_LD1: ldnx_q <= mem_rdata;
			sfa_pkg::S_LD2: ldpv_q <= mem_rdata;
			default: begin
				walk_q <= walk_q;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/segregated_fit_heap_allocator.sv
`default_nettype none
// channel    dir  fields (lowest bit up)
// s_axis     in   action, request_size, block_addr
// m_axis     out  result_addr, status
// cfg        in   index 0 extend_chunk_bytes, index 1 heap_limit_bytes
//
// one request at a time through a sequencer on a single-port heap ram (one access per cycle)
// free: time grows with the number of list unlinks during coalescing
// allocate: time grows with the number of free-list entries walked
// after reset the eight words of the initial heap image are written before the first beat is taken
// a new beat is taken while a finished result waits in the output register
module segregated_fit_heap_allocator #(
	parameter int HEAP_BYTES = sfa_pkg::HEAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,    // action, request_size, block_addr, zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,    // result_addr, status, zero pad
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [16:0] cfg_wdata
);

	localparam int IW = $clog2(HEAP_BYTES / 4);

	sfa_pkg::item_t   item;
	sfa_pkg::result_t res, out_q;
	logic             res_valid, res_take, in_fire, out_valid_q;
	logic [12:0]      chunk_q;
	logic [16:0]      limit_q;
	logic             mem_we;
	logic [IW-1:0]    mem_idx;
	logic [31:0]      mem_wdata, mem_rdata;

	// input beat unpack
	always_comb begin
		item.action       = s_tdata[0];
		item.request_size = s_tdata[16:1];
		item.block_addr   = s_tdata[32:17];
		in_fire           = s_tvalid & s_tready;
		res_take          = ~out_valid_q | m_tready;
		m_tvalid          = out_valid_q;
		m_tdata           = {6'b0, out_q.status, out_q.result_addr};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= 13'(sfa_pkg::CHUNK_RESET);
			limit_q <= 17'(sfa_pkg::LIMIT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				sfa_pkg::CFG_EXTEND_CHUNK: chunk_q <= cfg_wdata[12:0];
				sfa_pkg::CFG_HEAP_LIMIT:   limit_q <= cfg_wdata;
				default: limit_q <= limit_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) out_q <= res;
	end

	sfa_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.item               (item),
		.in_fire            (in_fire),
		.in_ready           (s_tready),
		.res                (res),
		.res_valid          (res_valid),
		.res_take           (res_take),
		.extend_chunk_bytes (chunk_q),
		.heap_limit_bytes   (limit_q),
		.mem_we             (mem_we),
		.mem_idx            (mem_idx),
		.mem_wdata          (mem_wdata),
		.mem_rdata          (mem_rdata)
	);

	sfa_mem #(.WORDS(HEAP_BYTES / 4)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.idx   (mem_idx),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

FILE: verif/tb_segregated_fit_heap_allocator.sv
`default_nettype none
module tb_segregated_fit_heap_allocator;
	import sfa_pkg::*;

	localparam int HEAP_WORDS = HEAP_BYTES_DEF / 4;
	localparam int WALK_MAX   = HEAP_BYTES_DEF / 24 + 1;
	localparam int unsigned CLASS_TOP [CLASS_COUNT-1] =
		'{24, 48, 72, 96, 120, 480, 960, 1920, 3840, 7680, 15360};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [16:0] cfg_wdata;

	segregated_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// shadow heap and allocator state
	logic [31:0] heap_img [HEAP_WORDS];
	int unsigned bin_head [CLASS_COUNT];
	int unsigned brk;
	int unsigned grow_chunk;
	int unsigned grow_limit;

	item_t       pending_reqs [$];
	result_t     expected_results [$];
	int unsigned live_blocks [$];
	int          error_count;
	int          beats_in;
	int          beats_out;
	int          n_alloc_ok, n_oom, n_null, n_free;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] heap_rd(input int unsigned a);
		return heap_img[(a >> 2) % HEAP_WORDS];
	endfunction

	function automatic void heap_wr(input int unsigned a, input logic [31:0] v);
		heap_img[(a >> 2) % HEAP_WORDS] = v;
	endfunction

	function automatic int unsigned block_size(input int unsigned a);
		return heap_rd(a) & ~32'd7;
	endfunction

	function automatic int unsigned size_bin(input int unsigned size);
		for (int c = 0; c < CLASS_COUNT - 1; c++)
			if (size <= CLASS_TOP[c])
				return c;
		return CLASS_COUNT - 1;
	endfunction

	function automatic void bin_push(input int unsigned bp, input int unsigned size);
		int unsigned c;
		int unsigned head;
		c = size_bin(size);
		head = bin_head[c];
		bin_head[c] = bp & 16'hFFFF;
		heap_wr(bp, head);
		heap_wr(bp + 8, 0);
		if (head != 0)
			heap_wr(head + 8, bp);
	endfunction

	function automatic void bin_unlink(input int unsigned bp, input int unsigned size);
		int unsigned nx;
		int unsigned pv;
		nx = heap_rd(bp);
		pv = heap_rd(bp + 8);
		if (pv == 0)
			bin_head[size_bin(size)] = nx & 16'hFFFF;
		else
			heap_wr(pv, nx);
		if (nx != 0)
			heap_wr(nx + 8, pv);
	endfunction

	// join a free block with free neighbors
	function automatic void coalesce(input int unsigned bp);
		int unsigned sz, pa, nx, na, nsz, pv, psz, h;
		sz = block_size(bp - 4);
		pa = heap_rd(bp - 4) & 2;
		nx = bp + sz;
		na = heap_rd(nx - 4) & 1;
		if (pa != 0 && na != 0)
			return;
		if (pa != 0) begin
			nsz = block_size(nx - 4);
			bin_unlink(bp, sz);
			bin_unlink(nx, nsz);
			sz += nsz;
			heap_wr(bp - 4, sz | pa);
			heap_wr(bp + sz - 8, sz | pa);
			bin_push(bp, sz);
			return;
		end
		pv = bp - block_size(bp - 8);
		psz = block_size(pv - 4);
		nsz = (na != 0) ? 0 : block_size(nx - 4);
		bin_unlink(bp, sz);
		bin_unlink(pv, psz);
		if (na == 0)
			bin_unlink(nx, nsz);
		sz += psz + nsz;
		h = sz | (heap_rd(pv - 4) & 2);
		heap_wr(pv - 4, h);
		heap_wr(pv + sz - 8, h);
		bin_push(pv, sz);
	endfunction

	// mark a block allocated, splitting off a usable remainder
	function automatic void carve(input int unsigned bp, input int unsigned asize);
		int unsigned cur, rem, pa, nx, v;
		cur = block_size(bp - 4);
		rem = cur - asize;
		bin_unlink(bp, cur);
		pa = heap_rd(bp - 4) & 2;
		if (rem >= MIN_BLOCK) begin
			heap_wr(bp - 4, asize | pa | 1);
			nx = bp + asize;
			heap_wr(nx - 4, rem | 2);
			heap_wr(nx + rem - 8, rem | 2);
			bin_push(nx, rem);
		end else begin
			heap_wr(bp - 4, cur | pa | 1);
			nx = bp + cur;
			v = heap_rd(nx - 4) | 2;
			heap_wr(nx - 4, v);
			if ((v & 1) == 0)
				heap_wr(nx + (v & ~32'd7) - 8, v);
		end
	endfunction

	function automatic int unsigned first_fit(input int unsigned asize);
		int unsigned bp;
		for (int c = size_bin(asize); c < CLASS_COUNT; c++) begin
			bp = bin_head[c];
			for (int n = 0; bp != 0 && n < WALK_MAX; n++) begin
				if (asize <= block_size(bp - 4))
					return bp;
				bp = heap_rd(bp);
			end
		end
		return 0;
	endfunction

	function automatic int unsigned extend_heap(input int unsigned bytes);
		int unsigned bp, h;
		bp = brk;
		h = bytes | (heap_rd(bp - 4) & 2);
		heap_wr(bp - 4, h);
		heap_wr(bp + bytes - 8, h);
		bin_push(bp, bytes);
		heap_wr(bp + bytes - 4, 1);
		brk = bp + bytes;
		coalesce(bp);
		// merged block starts at the old free tail when there was one
		return (heap_rd(bp - 4) & 1) == 0 && (heap_rd(bp - 4) & 2) == 0 ?
			bp - block_size(bp - 8) : bp;
	endfunction

	// work out the result of one request and update the shadow heap
	function automatic result_t serve(input item_t it);
		result_t r;
		int unsigned sz, nh, h, v, asize, bp, ext, lim, ptr;
		r.result_addr = '0;
		r.status = STAT_DONE;
		ptr = it.block_addr;
		if (it.action == ACT_FREE) begin
			if (ptr == 0) begin
				r.status = STAT_NULL;
				return r;
			end
			sz = block_size(ptr - 4);
			nh = ptr + sz - 4;
			h = sz | (heap_rd(ptr - 4) & 2);
			heap_wr(ptr - 4, h);
			heap_wr(ptr + sz - 8, h);
			v = heap_rd(nh);
			heap_wr(nh, (v & ~32'd7) | (v & 1));
			bin_push(ptr, sz);
			coalesce(ptr);
			return r;
		end
		if (it.request_size == 0) begin
			r.status = STAT_NULL;
			return r;
		end
		asize = (it.request_size <= 16) ? MIN_BLOCK : ((it.request_size + 11) & ~32'd7);
		bp = first_fit(asize);
		if (bp == 0) begin
			ext = grow_chunk & ~32'd7;
			if (asize > ext)
				ext = asize;
			lim = (grow_limit > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : grow_limit;
			if (brk + ext > lim) begin
				r.status = STAT_OOM;
				return r;
			end
			bp = extend_heap(ext);
		end
		carve(bp, asize);
		r.result_addr = bp & 16'hFFFF;
		return r;
	endfunction

	// predict, queue the beat and track live blocks
	task automatic issue(input item_t it);
		result_t r;
		r = serve(it);
		pending_reqs.push_back(it);
		expected_results.push_back(r);
		if (it.action == ACT_ALLOC && r.status == STAT_DONE) begin
			live_blocks.push_back(r.result_addr);
			n_alloc_ok++;
		end
		if (r.status == STAT_OOM)
			n_oom++;
		if (r.status == STAT_NULL)
			n_null++;
		if (it.action == ACT_FREE && r.status == STAT_DONE)
			n_free++;
	endtask

	task automatic issue_alloc(input int unsigned size);
		item_t it;
		it.action = ACT_ALLOC;
		it.request_size = size;
		it.block_addr = $urandom;
		issue(it);
	endtask

	// free a live block, sometimes with junk in the ignored low address bits
	task automatic issue_free_at(input int idx, input bit junk);
		item_t it;
		it.action = ACT_FREE;
		it.request_size = $urandom;
		it.block_addr = live_blocks[idx] | (junk ? $urandom_range(1, 3) : 0);
		live_blocks.delete(idx);
		issue(it);
	endtask

	task automatic issue_noise();
		item_t it;
		it.action = $urandom_range(0, 1) ? ACT_FREE : ACT_ALLOC;
		it.request_size = $urandom;
		it.block_addr = $urandom;
		case ($urandom_range(0, 2))
			0: it.request_size = 0;
			1: it.block_addr = 0;
			default: begin
				it.action = ACT_ALLOC;
				it.request_size = $urandom_range(60000, 65535);
			end
		endcase
		if (it.action == ACT_FREE)
			it.block_addr = 0;
		else if (it.request_size != 0 && it.request_size < 60000)
			it.request_size = 0;
		issue(it);
	endtask

	function automatic int unsigned pick_size(input bit big);
		int r;
		r = $urandom_range(0, 99);
		if (r < (big ? 30 : 70))
			return $urandom_range(1, 120);
		else if (r < (big ? 60 : 90))
			return $urandom_range(121, 1000);
		else if (r < 98)
			return $urandom_range(1001, big ? 8000 : 4000);
		else
			return $urandom_range(4001, 16000);
	endfunction

	task automatic run_random(input int count, input bit big);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				issue_noise();
			else if (r < 50 && live_blocks.size() > 0)
				issue_free_at($urandom_range(0, live_blocks.size() - 1),
					$urandom_range(0, 9) == 0);
			else
				issue_alloc(pick_size(big));
		end
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_EXTEND_CHUNK)
			grow_chunk = val & 17'h1FFF;
		else
			grow_limit = val & 17'h1FFFF;
	endtask

	task automatic set_config(input int unsigned chunk, input int unsigned lim);
		write_reg(CFG_EXTEND_CHUNK, chunk);
		write_reg(CFG_HEAP_LIMIT, lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// request driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
			beats_in <= 0;
		end else begin
			if (s_tvalid && s_tready)
				beats_in <= beats_in + 1;
			if (s_tvalid && !s_tready) begin
				// hold the beat
			end else if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() > 0) begin
				item_t it;
				it = pending_reqs.pop_front();
				s_tdata <= {7'd0, it.block_addr, it.request_size, it.action};
				s_tvalid <= 1'b1;
				if ((beats_in % 128) < 24)
					send_gap <= 0;
				else if ($urandom_range(0, 9) < 6)
					send_gap <= 0;
				else if ($urandom_range(0, 9) < 8)
					send_gap <= $urandom_range(1, 3);
				else
					send_gap <= $urandom_range(10, 40);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once the stream is under way
	int  hold_left;
	bit  hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && beats_in == 100) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and checker
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
			beats_out <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_t want;
				beats_out <= beats_out + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[15:0] !== want.result_addr) begin
						$error("result_addr expected %0d actual %0d", want.result_addr,
							m_tdata[15:0]);
						error_count++;
					end
					if (m_tdata[17:16] !== want.status) begin
						$error("status expected %0d actual %0d", want.status, m_tdata[17:16]);
						error_count++;
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				m_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if ((beats_out % 128) >= 24 && $urandom_range(0, 9) < 3)
					recv_gap <= ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
						: $urandom_range(15, 60);
			end
		end
	end

	// stimulus
	initial begin
		int unsigned dir_sizes [10] = '{1, 16, 17, 21, 100, 112, 2000, 15000, 15400, 480};
		error_count = 0;
		n_alloc_ok = 0;
		n_oom = 0;
		n_null = 0;
		n_free = 0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		foreach (heap_img[i])
			heap_img[i] = '0;
		foreach (bin_head[i])
			bin_head[i] = 0;
		heap_img[25] = 9;
		heap_img[26] = 9;
		heap_img[27] = 170;
		heap_img[68] = 170;
		heap_img[69] = 1;
		bin_head[INIT_HEAD_CLS] = INIT_HEAD_BP;
		brk = INIT_BREAK;
		grow_chunk = CHUNK_RESET;
		grow_limit = LIMIT_RESET;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: null requests, rounding edges, class extremes, oversize, coalescing
		issue_alloc(0);
		begin
			item_t it;
			it.action = ACT_FREE;
			it.request_size = 16'hFFFF;
			it.block_addr = 0;
			issue(it);
		end
		foreach (dir_sizes[i])
			issue_alloc(dir_sizes[i]);
		issue_alloc(65535);
		if (live_blocks.size() >= 6) begin
			issue_free_at(1, 1'b0);
			issue_free_at(2, 1'b0);
			issue_free_at(1, 1'b0);
			issue_free_at(0, 1'b1);
		end
		issue_alloc(40);
		issue_alloc(8);
		wait_idle();

		// smallest growth chunk
		set_config(24, 65536);
		run_random(200, 1'b0);
		wait_idle();

		// 4096-byte chunk, limit above the heap
		set_config(4096, 17'h1FFFF);
		run_random(200, 1'b1);
		wait_idle();

		// growth always refused, chunk low bits ignored
		set_config(4095, 280);
		run_random(150, 1'b0);
		wait_idle();

		set_config($urandom_range(3, 512) * 8, $urandom_range(20000, 65536));
		run_random(250, 1'b0);
		wait_idle();
		repeat (100) @(posedge clk);

		$display("covered %0d good allocations, %0d frees, %0d out of memory, %0d null",
			n_alloc_ok, n_free, n_oom, n_null);
		$display("over 5 register settings, %0d beats checked", beats_out);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#15000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
sv/sfa_pkg.sv
sv/sfa_mem.sv
sv/sfa_ctrl.sv
sv/segregated_fit_heap_allocator.sv
verif/tb_segregated_fit_heap_allocator.sv
